// ===== hw/rtl/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// lhp_pkg
// Types and constants shared by the layered coding transport header parser.
// ----------------------------------------------------------------------------
package lhp_pkg;

   // result kinds
   localparam logic [2:0] KIND_CCI      = 3'd0;
   localparam logic [2:0] KIND_EXT      = 3'd1;
   localparam logic [2:0] KIND_OK       = 3'd2;
   localparam logic [2:0] KIND_TRUNC    = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;
   localparam logic [2:0] KIND_BADEXT   = 3'd5;

   // fixed-size extension data length
   localparam logic [9:0] FIXED_EXT_LEN = 10'd3;

   // result queue geometry
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   typedef enum logic [7:0] {
      PH_FIRST    = 8'b0000_0001,
      PH_CCI      = 8'b0000_0010,
      PH_TSI      = 8'b0000_0100,
      PH_TOI      = 8'b0000_1000,
      PH_EXT_TYPE = 8'b0001_0000,
      PH_EXT_LEN  = 8'b0010_0000,
      PH_EXT_DATA = 8'b0100_0000,
      PH_SKIP     = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        run_end;
      logic [7:0]  ext_type;
      logic [7:0]  out_byte;
      logic [3:0]  version;
      logic [1:0]  psi_bits;
      logic [7:0]  codepoint;
      logic        sess_close;
      logic        obj_close;
      logic [47:0] session_id;
      logic [63:0] object_id_low;
      logic [47:0] object_id_high;
   } result_type;

   // results produced by one byte, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== hw/rtl/lct_header_parser.sv =====
// ----------------------------------------------------------------------------
// lct_header_parser
// Byte-serial layered coding transport header parser with result queue.
// ----------------------------------------------------------------------------
// data path: each byte is held in the input register, then the parse logic
//    writes its results into the result queue
// throughput: one byte per cycle; the input stalls only while the four-entry
//    result queue has fewer than two free entries
// reset: synchronous, clears parse state, input valid flag and queue pointers
module lct_header_parser
   import lhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic        rsp_run_end,
   output logic [7:0]  rsp_ext_type,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_version,
   output logic [1:0]  rsp_psi_bits,
   output logic [7:0]  rsp_codepoint,
   output logic        rsp_sess_close,
   output logic        rsp_obj_close,
   output logic [47:0] rsp_session_id,
   output logic [63:0] rsp_object_id_low,
   output logic [47:0] rsp_object_id_high
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       room, advance, req_take;
   push_type   push;
   result_type rsp_data;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   lhp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .push    (push)
   );

   lhp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (advance),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_run_end        = rsp_data.run_end;
   assign rsp_ext_type       = rsp_data.ext_type;
   assign rsp_out_byte       = rsp_data.out_byte;
   assign rsp_version        = rsp_data.version;
   assign rsp_psi_bits       = rsp_data.psi_bits;
   assign rsp_codepoint      = rsp_data.codepoint;
   assign rsp_sess_close     = rsp_data.sess_close;
   assign rsp_obj_close      = rsp_data.obj_close;
   assign rsp_session_id     = rsp_data.session_id;
   assign rsp_object_id_low  = rsp_data.object_id_low;
   assign rsp_object_id_high = rsp_data.object_id_high;

endmodule

// ===== hw/rtl/lhp_parser.sv =====
// ----------------------------------------------------------------------------
// lhp_parser
// Header parse state and per-byte next-state logic; yields up to two results.
// ----------------------------------------------------------------------------
module lhp_parser
   import lhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output push_type   push
);

   phase_type   phase_ff, phase_in;
   logic [9:0]  pos_ff, pos_in;
   logic [7:0]  hw_ff, hw_in;
   logic [23:0] fw_ff, fw_in;
   logic [4:0]  frem_ff, frem_in;
   logic [47:0] sess_ff, sess_in;
   logic [63:0] objl_ff, objl_in;
   logic [47:0] objh_ff, objh_in;
   logic [7:0]  etype_ff, etype_in;
   logic [9:0]  erem_ff, erem_in;

   logic       data_v, stat_v;
   logic [2:0] data_kind, stat_kind;
   logic [7:0] data_type;

   logic [9:0] hdr4, pos_next, need, hel, start, rem;
   logic [4:0] cci_len, tsi_len, toi_len, frem_dec;
   logic [9:0] erem_dec;
   logic [7:0] b1;
   logic       done_hdr;

   result_type data_res, stat_res;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      hw_in    = hw_ff;
      fw_in    = fw_ff;
      frem_in  = frem_ff;
      sess_in  = sess_ff;
      objl_in  = objl_ff;
      objh_in  = objh_ff;
      etype_in = etype_ff;
      erem_in  = erem_ff;

      data_v    = 1'b0;
      stat_v    = 1'b0;
      data_kind = KIND_CCI;
      stat_kind = KIND_OK;
      data_type = 8'd0;

      hdr4     = {hw_ff, 2'b00};
      pos_next = pos_ff + 10'd1;
      done_hdr = (pos_next >= hdr4);
      b1       = fw_ff[15:8];
      cci_len  = {({1'b0, fw_ff[19:18]} + 3'd1), 2'b00};
      tsi_len  = {2'b00, b1[7], b1[4], 1'b0};
      toi_len  = {1'b0, b1[6:5], b1[4], 1'b0};
      need     = 10'd4 + {5'd0, cci_len} + {5'd0, tsi_len} + {5'd0, toi_len};
      frem_dec = frem_ff - 5'd1;
      erem_dec = erem_ff - 10'd1;
      hel      = {in_byte, 2'b00};
      start    = pos_ff - 10'd1;
      rem      = ((pos_ff != 10'd0) && (hdr4 > start)) ? (hdr4 - start) : 10'd0;

      if (phase_ff != PH_SKIP) begin
         pos_in = pos_next;
         case (phase_ff)
            PH_FIRST: begin
               if (pos_ff == 10'd0) begin
                  fw_in = {in_byte, 16'd0};
               end else if (pos_ff == 10'd1) begin
                  fw_in = {fw_ff[23:16], in_byte, 8'd0};
               end else if (pos_ff == 10'd2) begin
                  hw_in = in_byte;
               end else begin
                  fw_in = {fw_ff[23:8], in_byte};
                  if (hdr4 < need) begin
                     stat_v    = 1'b1;
                     stat_kind = KIND_OVERFLOW;
                     phase_in  = PH_SKIP;
                  end else begin
                     phase_in = PH_CCI;
                     frem_in  = cci_len;
                  end
               end
            end
            PH_CCI: begin
               data_v    = 1'b1;
               data_kind = KIND_CCI;
               frem_in   = frem_dec;
               if (frem_dec == 5'd0) begin
                  if (tsi_len != 5'd0) begin
                     phase_in = PH_TSI;
                     frem_in  = tsi_len;
                  end else if (toi_len != 5'd0) begin
                     phase_in = PH_TOI;
                     frem_in  = toi_len;
                  end else if (done_hdr) begin
                     stat_v   = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_EXT_TYPE;
                  end
               end
            end
            PH_TSI: begin
               sess_in = {sess_ff[39:0], in_byte};
               frem_in = frem_dec;
               if (frem_dec == 5'd0) begin
                  if (toi_len != 5'd0) begin
                     phase_in = PH_TOI;
                     frem_in  = toi_len;
                  end else if (done_hdr) begin
                     stat_v   = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_EXT_TYPE;
                  end
               end
            end
            PH_TOI: begin
               objh_in = {objh_ff[39:0], objl_ff[63:56]};
               objl_in = {objl_ff[55:0], in_byte};
               frem_in = frem_dec;
               if (frem_dec == 5'd0) begin
                  if (done_hdr) begin
                     stat_v   = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_EXT_TYPE;
                  end
               end
            end
            PH_EXT_TYPE: begin
               etype_in = in_byte;
               if (in_byte[7]) begin
                  erem_in  = FIXED_EXT_LEN;
                  phase_in = PH_EXT_DATA;
               end else begin
                  phase_in = PH_EXT_LEN;
               end
            end
            PH_EXT_LEN: begin
               if ((hel == 10'd0) || (hel > rem)) begin
                  stat_v    = 1'b1;
                  stat_kind = KIND_BADEXT;
                  phase_in  = PH_SKIP;
               end else begin
                  erem_in  = hel - 10'd2;
                  phase_in = PH_EXT_DATA;
               end
            end
            PH_EXT_DATA: begin
               data_v    = 1'b1;
               data_kind = KIND_EXT;
               data_type = etype_ff;
               erem_in   = erem_dec;
               if (erem_dec == 10'd0) begin
                  if (done_hdr) begin
                     stat_v   = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_EXT_TYPE;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         // packet ended before the header did
         if (in_last && (phase_in != PH_SKIP)) begin
            stat_v    = 1'b1;
            stat_kind = KIND_TRUNC;
         end
      end

      data_res          = '0;
      data_res.kind     = data_kind;
      data_res.ext_type = data_type;
      data_res.out_byte = in_byte;
      data_res.run_end  = !stat_v;

      stat_res         = '0;
      stat_res.kind    = stat_kind;
      stat_res.run_end = 1'b1;
      if (stat_kind == KIND_OK) begin
         stat_res.version        = fw_in[23:20];
         stat_res.psi_bits       = fw_in[17:16];
         stat_res.codepoint      = fw_in[7:0];
         stat_res.sess_close     = fw_in[9];
         stat_res.obj_close      = fw_in[8];
         stat_res.session_id     = sess_in;
         stat_res.object_id_low  = objl_in;
         stat_res.object_id_high = objh_in;
      end

      push.count  = {1'b0, data_v} + {1'b0, stat_v};
      push.first  = data_v ? data_res : stat_res;
      push.second = stat_res;

      if (in_last) begin
         phase_in = PH_FIRST;
         pos_in   = 10'd0;
         hw_in    = 8'd0;
         fw_in    = 24'd0;
         frem_in  = 5'd0;
         sess_in  = 48'd0;
         objl_in  = 64'd0;
         objh_in  = 48'd0;
         etype_in = 8'd0;
         erem_in  = 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         pos_ff   <= 10'd0;
         hw_ff    <= 8'd0;
         fw_ff    <= 24'd0;
         frem_ff  <= 5'd0;
         sess_ff  <= 48'd0;
         objl_ff  <= 64'd0;
         objh_ff  <= 48'd0;
         etype_ff <= 8'd0;
         erem_ff  <= 10'd0;
      end else if (enable) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         hw_ff    <= hw_in;
         fw_ff    <= fw_in;
         frem_ff  <= frem_in;
         sess_ff  <= sess_in;
         objl_ff  <= objl_in;
         objh_ff  <= objh_in;
         etype_ff <= etype_in;
         erem_ff  <= erem_in;
      end
   end

endmodule

// ===== hw/rtl/lhp_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// lhp_rsp_queue
// Small result queue; takes up to two results per cycle, delivers one while not stalled.
// ----------------------------------------------------------------------------
module lhp_rsp_queue
   import lhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_en,
   input  push_type   push,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   result_type     q_ff [QDEPTH];
   logic [QAW-1:0] head_ff, head_in, tail_ff, tail_in, tail_nx;
   logic [QAW:0]   cnt_ff, cnt_in;
   logic [1:0]     n_push;
   logic           pop;

   assign tail_nx   = tail_ff + QAW'(1);
   assign n_push    = push_en ? push.count : 2'd0;
   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = q_ff[head_ff];
   // two free entries guarantee space for the results of any one byte
   assign room      = (cnt_ff <= (QAW+1)'(QDEPTH - 2));

   always_comb begin
      head_in = pop ? head_ff + QAW'(1) : head_ff;
      tail_in = tail_ff + QAW'(n_push);
      cnt_in  = cnt_ff + (QAW+1)'(n_push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_ff[tail_ff] <= push.first;
      end
      if (n_push == 2'd2) begin
         q_ff[tail_nx] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== dv/lct_header_parser_checker.sv =====
// ----------------------------------------------------------------------------
// lct_header_parser_checker
// Watches both channels of the header parser and keeps its own model of the
// parse. Each accepted packet byte is parsed and the results that it should
// cause are queued. Each accepted result is then compared, field by field,
// with the oldest queued one.
// ----------------------------------------------------------------------------
module lct_header_parser_checker
   import lhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic        rsp_run_end,
   input  logic [7:0]  rsp_ext_type,
   input  logic [7:0]  rsp_out_byte,
   input  logic [3:0]  rsp_version,
   input  logic [1:0]  rsp_psi_bits,
   input  logic [7:0]  rsp_codepoint,
   input  logic        rsp_sess_close,
   input  logic        rsp_obj_close,
   input  logic [47:0] rsp_session_id,
   input  logic [63:0] rsp_object_id_low,
   input  logic [47:0] rsp_object_id_high,
   output int          fail_count,
   output int          outstanding
);

   // parse state
   phase_type   phase;
   logic [9:0]  byte_pos;
   logic [7:0]  hdr_words;
   logic [23:0] word0;
   logic [4:0]  field_left;
   logic [47:0] tsi_acc;
   logic [63:0] toi_lo;
   logic [47:0] toi_hi;
   logic [7:0]  ext_kind;
   logic [9:0]  ext_left;

   result_type  results_due[$];
   result_type  want;
   int          errors = 0;

   function automatic void clear_state();
      phase      = PH_FIRST;
      byte_pos   = '0;
      hdr_words  = '0;
      word0      = '0;
      field_left = '0;
      tsi_acc    = '0;
      toi_lo     = '0;
      toi_hi     = '0;
      ext_kind   = '0;
      ext_left   = '0;
   endfunction

   function automatic int cci_bytes();
      return 4 * (int'(word0[19:18]) + 1);
   endfunction

   function automatic int tsi_bytes();
      return 4 * int'(word0[15]) + 2 * int'(word0[12]);
   endfunction

   function automatic int toi_bytes();
      return 4 * int'(word0[14:13]) + 2 * int'(word0[12]);
   endfunction

   function automatic void post_result(logic [2:0] kind, logic [7:0] xtype, logic [7:0] data);
      result_type r;
      r = '0;
      r.kind     = kind;
      r.ext_type = xtype;
      r.out_byte = data;
      if (kind == KIND_OK) begin
         r.version        = word0[23:20];
         r.psi_bits       = word0[17:16];
         r.codepoint      = word0[7:0];
         r.sess_close     = word0[9];
         r.obj_close      = word0[8];
         r.session_id     = tsi_acc;
         r.object_id_low  = toi_lo;
         r.object_id_high = toi_hi;
      end
      results_due.push_back(r);
   endfunction

   function automatic void ext_or_done();
      if (int'(byte_pos) >= 4 * int'(hdr_words)) begin
         post_result(KIND_OK, 8'h00, 8'h00);
         phase = PH_SKIP;
      end else begin
         phase = PH_EXT_TYPE;
      end
   endfunction

   // stage 0 follows cci, 1 follows tsi, 2 follows toi
   function automatic void next_field(int stage);
      if (stage == 0 && tsi_bytes() > 0) begin
         phase      = PH_TSI;
         field_left = 5'(tsi_bytes());
      end else if (stage <= 1 && toi_bytes() > 0) begin
         phase      = PH_TOI;
         field_left = 5'(toi_bytes());
      end else begin
         ext_or_done();
      end
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic last);
      int         p;
      int         hel;
      int         rem;
      int         count_before;
      result_type tail;
      count_before = results_due.size();
      if (phase != PH_SKIP) begin
         p = int'(byte_pos);
         byte_pos = byte_pos + 10'd1;
         case (phase)
            PH_FIRST: begin
               if (p == 0) begin
                  word0 = {b, 16'h0000};
               end else if (p == 1) begin
                  word0[15:8] = b;
               end else if (p == 2) begin
                  hdr_words = b;
               end else begin
                  word0[7:0] = b;
                  if (4 * int'(hdr_words) < 4 + cci_bytes() + tsi_bytes() + toi_bytes()) begin
                     post_result(KIND_OVERFLOW, 8'h00, 8'h00);
                     phase = PH_SKIP;
                  end else begin
                     phase      = PH_CCI;
                     field_left = 5'(cci_bytes());
                  end
               end
            end
            PH_CCI: begin
               post_result(KIND_CCI, 8'h00, b);
               field_left = field_left - 5'd1;
               if (field_left == 0) next_field(0);
            end
            PH_TSI: begin
               tsi_acc    = {tsi_acc[39:0], b};
               field_left = field_left - 5'd1;
               if (field_left == 0) next_field(1);
            end
            PH_TOI: begin
               toi_hi     = {toi_hi[39:0], toi_lo[63:56]};
               toi_lo     = {toi_lo[55:0], b};
               field_left = field_left - 5'd1;
               if (field_left == 0) next_field(2);
            end
            PH_EXT_TYPE: begin
               ext_kind = b;
               if (b[7]) begin
                  ext_left = FIXED_EXT_LEN;
                  phase    = PH_EXT_DATA;
               end else begin
                  phase = PH_EXT_LEN;
               end
            end
            PH_EXT_LEN: begin
               // room left counts from the type byte of this extension
               hel = 4 * int'(b);
               rem = 4 * int'(hdr_words) - (p - 1);
               if (rem < 0) rem = 0;
               if (hel == 0 || hel > rem) begin
                  post_result(KIND_BADEXT, 8'h00, 8'h00);
                  phase = PH_SKIP;
               end else begin
                  ext_left = 10'(hel - 2);
                  phase    = PH_EXT_DATA;
               end
            end
            default: begin
               post_result(KIND_EXT, ext_kind, b);
               ext_left = ext_left - 10'd1;
               if (ext_left == 0) ext_or_done();
            end
         endcase
         if (last && phase != PH_SKIP) post_result(KIND_TRUNC, 8'h00, 8'h00);
      end
      if (results_due.size() > count_before) begin
         tail = results_due.pop_back();
         tail.run_end = 1'b1;
         results_due.push_back(tail);
      end
      if (last) clear_state();
   endfunction

   function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, expected,
                  actual);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         results_due.delete();
         clear_state();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: result with nothing expected, actual kind %0d byte 'h%0h",
                        $time, rsp_kind, rsp_out_byte);
               errors++;
            end else begin
               want = results_due.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_kind));
               check_field("run_end", 64'(want.run_end), 64'(rsp_run_end));
               check_field("ext_type", 64'(want.ext_type), 64'(rsp_ext_type));
               check_field("out_byte", 64'(want.out_byte), 64'(rsp_out_byte));
               check_field("version", 64'(want.version), 64'(rsp_version));
               check_field("psi_bits", 64'(want.psi_bits), 64'(rsp_psi_bits));
               check_field("codepoint", 64'(want.codepoint), 64'(rsp_codepoint));
               check_field("sess_close", 64'(want.sess_close), 64'(rsp_sess_close));
               check_field("obj_close", 64'(want.obj_close), 64'(rsp_obj_close));
               check_field("session_id", 64'(want.session_id), 64'(rsp_session_id));
               check_field("object_id_low", want.object_id_low, rsp_object_id_low);
               check_field("object_id_high", 64'(want.object_id_high), 64'(rsp_object_id_high));
            end
         end
         if (req_valid && !req_stall) parse_byte(req_in_byte, req_in_last);
      end
      fail_count  <= errors;
      outstanding <= results_due.size();
   end

endmodule

// ===== dv/lct_header_parser_test.sv =====
// ----------------------------------------------------------------------------
// lct_header_parser_test
// Feeds the header parser with packets, byte by byte: four hand-made ones for
// overflow, a short complete header, truncation and a bad extension, then
// random packets that are mostly well formed, some broken and some plain
// noise. Channels idle at random; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module lct_header_parser_test;
   import lhp_pkg::*;

   localparam int ITEM_TARGET  = 2000;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 10;

   // packet shapes
   localparam int MODE_GOOD     = 0;
   localparam int MODE_TRUNC    = 1;
   localparam int MODE_OVERFLOW = 2;
   localparam int MODE_BADEXT   = 3;
   localparam int MODE_NOISE    = 4;
   localparam int MODE_LARGE    = 5;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic        rsp_run_end;
   logic [7:0]  rsp_ext_type;
   logic [7:0]  rsp_out_byte;
   logic [3:0]  rsp_version;
   logic [1:0]  rsp_psi_bits;
   logic [7:0]  rsp_codepoint;
   logic        rsp_sess_close;
   logic        rsp_obj_close;
   logic [47:0] rsp_session_id;
   logic [63:0] rsp_object_id_low;
   logic [47:0] rsp_object_id_high;
   int          fail_count;
   int          outstanding;

   int          cycle_count = 0;
   int          quiet_cycles = 0;
   int          bytes_sent = 0;
   logic [7:0]  pkt[$];
   logic        calm;

   // a stretch with no idling on either side
   assign calm = (cycle_count >= 1200 && cycle_count < 1800);

   initial forever #5 clock = ~clock;

   lct_header_parser uut (.*);

   lct_header_parser_checker monitor_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall   <= !calm && ($urandom_range(99) < 31);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic build_packet(input int mode);
      int         c, s, o, h;
      int         base, words, hel, start, rem, cut;
      logic [7:0] ext_bytes[$];
      pkt.delete();
      if (mode == MODE_NOISE) begin
         repeat ($urandom_range(12, 1)) pkt.push_back(8'($urandom));
         return;
      end
      c = $urandom_range(3);
      s = $urandom_range(1);
      o = $urandom_range(3);
      h = $urandom_range(1);
      base = 4 + 4 * (c + 1) + (4 * s + 2 * h) + (4 * o + 2 * h);
      if (mode == MODE_LARGE) begin
         // one variable extension fills the header out to 255 words
         hel = (1020 - base) / 4;
         ext_bytes.push_back(8'($urandom_range(127)));
         ext_bytes.push_back(8'(hel));
         repeat (4 * hel - 2) ext_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(3)) begin
            if ($urandom_range(1) == 1) begin
               ext_bytes.push_back(8'($urandom_range(255, 128)));
               repeat (3) ext_bytes.push_back(8'($urandom));
            end else begin
               hel = $urandom_range(4, 1);
               ext_bytes.push_back(8'($urandom_range(127)));
               ext_bytes.push_back(8'(hel));
               repeat (4 * hel - 2) ext_bytes.push_back(8'($urandom));
            end
         end
      end
      words = (base + ext_bytes.size()) / 4;
      if (mode == MODE_OVERFLOW) begin
         words = $urandom_range(base / 4 - 1);
      end else if (mode == MODE_BADEXT) begin
         // length byte either zero or past the end of the header
         start = base + ext_bytes.size();
         words = start / 4 + 1 + $urandom_range(1);
         rem   = 4 * words - start;
         ext_bytes.push_back(8'($urandom_range(127)));
         ext_bytes.push_back(($urandom_range(1) == 1) ? 8'h00 : 8'(rem / 4 + $urandom_range(3, 1)));
         repeat (2) ext_bytes.push_back(8'($urandom));
      end
      pkt.push_back({4'($urandom), 2'(c), 2'($urandom)});
      pkt.push_back({1'(s), 2'(o), 1'(h), 4'($urandom)});
      pkt.push_back(8'(words));
      pkt.push_back(8'($urandom));
      repeat (base - 4) pkt.push_back(8'($urandom));
      foreach (ext_bytes[i]) pkt.push_back(ext_bytes[i]);
      if (mode == MODE_TRUNC) begin
         cut = $urandom_range(4 * words - 1, 1);
         while (pkt.size() > cut) void'(pkt.pop_back());
      end else begin
         repeat ($urandom_range(4)) pkt.push_back(8'($urandom));
      end
   endtask

   initial begin
      int pick;
      int packets;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_byte <= 8'h00;
      req_in_last <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every field at its widest against a zero header length
      pkt = '{8'hFF, 8'hF3, 8'h00, 8'hFF};
      send_packet();
      // shortest complete header: first word and four cci bytes
      pkt = '{8'h00, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55};
      send_packet();
      // packet ending on its first byte
      pkt = '{8'h00};
      send_packet();
      // zero extension length, then a trailing byte
      pkt = '{8'h00, 8'h00, 8'h03, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h05, 8'h00, 8'hAB};
      send_packet();

      packets = 0;
      while (bytes_sent < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (packets == 6) build_packet(MODE_LARGE);
         else if (pick < 70) build_packet(MODE_GOOD);
         else if (pick < 78) build_packet(MODE_TRUNC);
         else if (pick < 85) build_packet(MODE_OVERFLOW);
         else if (pick < 93) build_packet(MODE_BADEXT);
         else build_packet(MODE_NOISE);
         send_packet();
         packets++;
      end
      req_valid <= 1'b0;
      // let the checker count the results of the last transaction
      @(posedge clock);

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== lct_header_parser.f =====
hw/rtl/lhp_pkg.sv
hw/rtl/lhp_parser.sv
hw/rtl/lhp_rsp_queue.sv
hw/rtl/lct_header_parser.sv
dv/lct_header_parser_checker.sv
dv/lct_header_parser_test.sv
